// ===== rtl/mfde_pkg.sv =====
// Package: opcodes, FSM states and store geometry for the draw engine
`timescale 1ns / 1ps
package mfde_pkg;

   typedef enum logic [2:0] {
      OP_POINT = 3'd0,
      OP_RECT  = 3'd1,
      OP_LINE  = 3'd2,
      OP_CLEAR = 3'd3,
      OP_READ  = 3'd4
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_PIX,
      ST_RD,
      ST_WR,
      ST_RSP
   } state_type;

   localparam int unsigned PAGES = 8;

endpackage

// ===== rtl/mfde_ram.sv =====
// Generic single-port RAM with registered read
`timescale 1ns / 1ps
module mfde_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

// ===== rtl/mono_framebuffer_draw_engine.sv =====
// Top level: command sequencer with pixel walker over the frame store
`timescale 1ns / 1ps
// Channel  | Valid      | Stall      | Payload
// request  | req_valid  | req_stall  | opcode x_a y_a x_b y_b pixel_on read_column read_page
// response | rsp_valid  | rsp_stall  | read_byte
// After accept, each on-screen pixel of a point, rect or line passes ST_PIX, ST_RD, ST_WR
// (read then write on the single-port store), an off-screen one ST_PIX, ST_WR; a read passes
// ST_RD, ST_WR, a clear sweeps the store, an empty rect or unused opcode goes to ST_RSP.
// Reset runs the clear sweep before the first item is taken.
// A held response blocks further items; the result register holds until taken.
module mono_framebuffer_draw_engine
   import mfde_pkg::*;
#(
   parameter int unsigned SCREEN_WIDTH  = 128,
   parameter int unsigned SCREEN_HEIGHT = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_opcode,
   input  logic [7:0] req_x_a,
   input  logic [7:0] req_y_a,
   input  logic [7:0] req_x_b,
   input  logic [7:0] req_y_b,
   input  logic       req_pixel_on,
   input  logic [6:0] req_read_column,
   input  logic [2:0] req_read_page,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_byte
);

   localparam int unsigned DEPTH = SCREEN_WIDTH * PAGES;
   localparam int unsigned AW    = $clog2(DEPTH);

   state_type state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic boot_ff, boot_in;
   logic [2:0] op_ff, op_in;
   logic on_ff, on_in;
   logic [7:0] rb_ff, rb_in;
   // walker registers (signed 10 bits covers -1..256)
   logic signed [9:0] cx_ff, cx_in, cy_ff, cy_in;   // current coordinate
   logic signed [9:0] ex_ff, ex_in, ey_ff, ey_in;   // end / minor target
   logic signed [9:0] y0_ff, y0_in;                 // rect column start
   logic [8:0] err_ff, err_in, dmaj_ff, dmaj_in, dmin_ff, dmin_in;
   logic [8:0] n_ff, n_in;
   logic xmaj_ff, xmaj_in;
   logic [7:0] px, py;
   logic pix_ok;
   logic [AW-1:0] paddr_ff, paddr_in;
   logic [7:0] mask_ff, mask_in;

   logic we;
   logic [AW-1:0] addr;
   logic [7:0] wdata, rdata;

   mfde_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
      .clock(clock), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         boot_ff  <= 1'b1;
         op_ff    <= 3'(OP_CLEAR);
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         boot_ff  <= boot_in;
         op_ff    <= op_in;
      end
      on_ff <= on_in; rb_ff <= rb_in;
      cx_ff <= cx_in; cy_ff <= cy_in; ex_ff <= ex_in; ey_ff <= ey_in;
      y0_ff <= y0_in; err_ff <= err_in; dmaj_ff <= dmaj_in; dmin_ff <= dmin_in;
      n_ff <= n_in; xmaj_ff <= xmaj_in; paddr_ff <= paddr_in; mask_ff <= mask_in;
   end

   logic [8:0] adx, ady;
   logic done_pix;
   logic signed [9:0] nx, ny;
   logic [8:0] nerr;

   always_comb begin
      state_in = state_ff; clr_in = clr_ff; boot_in = boot_ff; op_in = op_ff;
      on_in = on_ff; rb_in = rb_ff;
      cx_in = cx_ff; cy_in = cy_ff; ex_in = ex_ff; ey_in = ey_ff; y0_in = y0_ff;
      err_in = err_ff; dmaj_in = dmaj_ff; dmin_in = dmin_ff; n_in = n_ff;
      xmaj_in = xmaj_ff; paddr_in = paddr_ff; mask_in = mask_ff;
      we = 1'b0; addr = paddr_ff; wdata = 8'd0;
      req_stall = 1'b1; rsp_valid = 1'b0;
      adx = (req_x_a > req_x_b) ? 9'(req_x_a - req_x_b) : 9'(req_x_b - req_x_a);
      ady = (req_y_a > req_y_b) ? 9'(req_y_a - req_y_b) : 9'(req_y_b - req_y_a);
      done_pix = 1'b0; nx = cx_ff; ny = cy_ff; nerr = err_ff;
      px = cx_ff[7:0]; py = cy_ff[7:0]; pix_ok = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               op_in = req_opcode; on_in = req_pixel_on; rb_in = 8'd0;
               unique case (req_opcode)
                  OP_POINT: begin
                     cx_in = 10'(req_x_a); cy_in = 10'(req_y_a);
                     ex_in = 10'(req_x_a); ey_in = 10'(req_y_a);
                     state_in = ST_PIX;
                  end
                  OP_RECT: begin
                     cx_in = 10'(req_x_a); cy_in = 10'(req_y_a);
                     ex_in = 10'(req_x_b); ey_in = 10'(req_y_b);
                     y0_in = 10'(req_y_a);
                     state_in = (req_x_a > req_x_b || req_y_a > req_y_b) ? ST_RSP : ST_PIX;
                  end
                  OP_LINE: begin
                     on_in = 1'b1;
                     xmaj_in = ady < adx;
                     n_in = 9'd0;
                     if (ady < adx) begin
                        dmaj_in = adx; dmin_in = ady; err_in = ady;
                        if (req_x_a > req_x_b) begin
                           cx_in = 10'(req_x_b); cy_in = 10'(req_y_b);
                           ex_in = 10'(req_x_a); ey_in = 10'(req_y_a);
                        end else begin
                           cx_in = 10'(req_x_a); cy_in = 10'(req_y_a);
                           ex_in = 10'(req_x_b); ey_in = 10'(req_y_b);
                        end
                     end else begin
                        dmaj_in = ady; dmin_in = adx; err_in = adx;
                        if (req_y_a > req_y_b) begin
                           cx_in = 10'(req_x_b); cy_in = 10'(req_y_b);
                           ex_in = 10'(req_x_a); ey_in = 10'(req_y_a);
                        end else begin
                           cx_in = 10'(req_x_a); cy_in = 10'(req_y_a);
                           ex_in = 10'(req_x_b); ey_in = 10'(req_y_b);
                        end
                     end
                     state_in = ST_PIX;
                  end
                  OP_CLEAR: begin
                     clr_in = '0; state_in = ST_CLEAR;
                  end
                  OP_READ: begin
                     if ({1'b0, req_read_column} < 8'(SCREEN_WIDTH)) begin
                        paddr_in = AW'({req_read_column, req_read_page});
                        state_in = ST_RD;
                     end else begin
                        state_in = ST_RSP;
                     end
                  end
                  default: state_in = ST_RSP;
               endcase
            end
         end
         ST_CLEAR: begin
            we = 1'b1; addr = clr_ff; wdata = 8'd0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(DEPTH - 1)) begin
               // the sweep after reset answers no item
               state_in = boot_ff ? ST_IDLE : ST_RSP;
               boot_in = 1'b0;
            end
         end
         ST_PIX: begin
            // apply line minor step, then compute address of the current pixel
            if (op_ff == 3'(OP_LINE)) begin
               if (err_ff >= dmaj_ff) begin
                  nerr = err_ff - dmaj_ff;
                  if (xmaj_ff) ny = (cy_ff < ey_ff) ? cy_ff + 10'sd1 : cy_ff - 10'sd1;
                  else         nx = (cx_ff < ex_ff) ? cx_ff + 10'sd1 : cx_ff - 10'sd1;
               end
               err_in = nerr + dmin_ff;
               cx_in = nx; cy_in = ny;
               px = nx[7:0]; py = ny[7:0];
            end
            pix_ok = ({1'b0, px} < 9'(SCREEN_WIDTH)) && ({1'b0, py} < 9'(SCREEN_HEIGHT));
            paddr_in = AW'({px, ~py[5:3]});
            mask_in = pix_ok ? (8'h80 >> py[2:0]) : 8'd0;
            state_in = pix_ok ? ST_RD : ST_WR;
         end
         ST_RD: begin
            state_in = ST_WR;
         end
         ST_WR: begin
            if (op_ff == 3'(OP_READ)) begin
               rb_in = rdata; state_in = ST_RSP;
            end else begin
               if (mask_ff != 8'd0) begin
                  we = 1'b1;
                  wdata = on_ff ? (rdata | mask_ff) : (rdata & ~mask_ff);
               end
               // advance the walk
               if (op_ff == 3'(OP_LINE)) begin
                  done_pix = (n_ff == dmaj_ff);
                  n_in = n_ff + 1'b1;
                  if (xmaj_ff) cx_in = cx_ff + 10'sd1;
                  else         cy_in = cy_ff + 10'sd1;
               end else if (op_ff == 3'(OP_RECT)) begin
                  if (cy_ff == ey_ff) begin
                     // column done: restart y at the first corner
                     cy_in = y0_ff;
                     if (cx_ff == ex_ff) done_pix = 1'b1;
                     cx_in = cx_ff + 10'sd1;
                  end else begin
                     cy_in = cy_ff + 10'sd1;
                  end
               end else begin
                  done_pix = 1'b1;
               end
               state_in = done_pix ? ST_RSP : ST_PIX;
            end
         end
         ST_RSP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_read_byte = rb_ff;

   a_rsp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && op_ff != 3'(OP_READ) |-> rsp_read_byte == 8'd0)
      else $error("nonzero byte for non-read item");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> req_stall)
      else $error("item taken while busy");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_byte))
      else $error("result dropped");

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for the draw engine: table of directed commands, then random commands vs a predictor
`timescale 1ns / 1ps
module testbench;
   import mfde_pkg::*;

   localparam int unsigned WIDTH  = 128;
   localparam int unsigned HEIGHT = 64;
   localparam int unsigned NUM_RANDOM = 1300;

   typedef struct packed {
      logic [2:0] opcode;
      logic [7:0] x_a;
      logic [7:0] y_a;
      logic [7:0] x_b;
      logic [7:0] y_b;
      logic       pixel_on;
      logic [6:0] read_column;
      logic [2:0] read_page;
   } command_type;

   typedef struct {
      command_type cmd;
      logic     has_byte;
      logic [7:0] byte_val;
   } table_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_opcode = '0;
   logic [7:0] req_x_a = '0;
   logic [7:0] req_y_a = '0;
   logic [7:0] req_x_b = '0;
   logic [7:0] req_y_b = '0;
   logic       req_pixel_on = 1'b0;
   logic [6:0] req_read_column = '0;
   logic [2:0] req_read_page = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_read_byte;

   logic [7:0] pixel_store [WIDTH*PAGES];
   logic [7:0] byte_queue [$];
   int unsigned error_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned hold_off_cycles = 0;

   mono_framebuffer_draw_engine #(.SCREEN_WIDTH(WIDTH), .SCREEN_HEIGHT(HEIGHT)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_opcode(req_opcode), .req_x_a(req_x_a), .req_y_a(req_y_a),
      .req_x_b(req_x_b), .req_y_b(req_y_b), .req_pixel_on(req_pixel_on),
      .req_read_column(req_read_column), .req_read_page(req_read_page),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_read_byte(rsp_read_byte)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #200_000_000;
      $display("mono_framebuffer_draw_engine: mismatch");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("ERROR %0t: %s", $realtime, what);
      error_count++;
   endtask

   function automatic void plot_pixel(input int px, input int py, input logic on);
      int ux;
      int uy;
      int page;
      ux = px & 8'hFF;
      uy = py & 8'hFF;
      if (ux >= WIDTH || uy >= HEIGHT) return;
      page = 7 - (uy / 8);
      if (on) pixel_store[ux*PAGES + page][7 - uy % 8] = 1'b1;
      else pixel_store[ux*PAGES + page][7 - uy % 8] = 1'b0;
   endfunction

   function automatic void walk_line(input int ax, input int ay, input int bx, input int by);
      int dx;
      int dy;
      int t;
      int err;
      dx = ax > bx ? ax - bx : bx - ax;
      dy = ay > by ? ay - by : by - ay;
      if (dy < dx) begin
         if (ax > bx) begin
            t = ax; ax = bx; bx = t;
            t = ay; ay = by; by = t;
         end
         err = dy;
         for (int n = 0; n <= dx; n++) begin
            if (err >= dx) begin
               err -= dx;
               ay += (ay < by) ? 1 : -1;
            end
            err += dy;
            plot_pixel(ax, ay, 1'b1);
            ax++;
         end
      end else begin
         if (ay > by) begin
            t = ax; ax = bx; bx = t;
            t = ay; ay = by; by = t;
         end
         err = dx;
         for (int n = 0; n <= dy; n++) begin
            if (err >= dy) begin
               err -= dy;
               ax += (ax < bx) ? 1 : -1;
            end
            err += dx;
            plot_pixel(ax, ay, 1'b1);
            ay++;
         end
      end
   endfunction

   function automatic logic [7:0] apply_command(input command_type c);
      logic [7:0] rb;
      rb = '0;
      case (c.opcode)
         OP_POINT: plot_pixel(c.x_a, c.y_a, c.pixel_on);
         OP_RECT: begin
            for (int x = c.x_a; x <= c.x_b; x++)
               for (int y = c.y_a; y <= c.y_b; y++)
                  plot_pixel(x, y, c.pixel_on);
         end
         OP_LINE: walk_line(c.x_a, c.y_a, c.x_b, c.y_b);
         OP_CLEAR: foreach (pixel_store[i]) pixel_store[i] = '0;
         OP_READ: begin
            if (c.read_column < WIDTH) rb = pixel_store[c.read_column*PAGES + c.read_page];
         end
         default: ;
      endcase
      return rb;
   endfunction

   // drive one item and hold it until accepted; valid is left high when the task returns
   task automatic send_command(input command_type c);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_opcode, req_x_a, req_y_a, req_x_b, req_y_b, req_pixel_on,
       req_read_column, req_read_page} <= c;
      byte_queue.push_back(apply_command(c));
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic command_type make_command(input logic [2:0] op, input int xa,
                                                input int ya, input int xb, input int yb,
                                                input logic on, input int col, input int pg);
      command_type c;
      c.opcode = op; c.x_a = 8'(xa); c.y_a = 8'(ya); c.x_b = 8'(xb); c.y_b = 8'(yb);
      c.pixel_on = on; c.read_column = 7'(col); c.read_page = 3'(pg);
      return c;
   endfunction

   function automatic command_type random_command();
      command_type c;
      int r;
      c = $bits(command_type)'({$urandom, $urandom});
      r = $urandom_range(99);
      if (r < 30) c.opcode = OP_READ;
      else if (r < 50) c.opcode = OP_POINT;
      else if (r < 65) c.opcode = OP_LINE;
      else if (r < 80) c.opcode = OP_RECT;
      else if (r < 82) c.opcode = OP_CLEAR;
      else if (r < 84) c.opcode = 3'($urandom_range(5, 7));
      else c.opcode = OP_READ;
      // keep most coordinates on screen and most rects small
      if ($urandom_range(9) < 8) begin
         c.x_a = 8'($urandom_range(WIDTH - 1));
         c.y_a = 8'($urandom_range(HEIGHT - 1));
         if (c.opcode == OP_RECT) begin
            c.x_b = 8'(c.x_a + $urandom_range(6) - 1);
            c.y_b = 8'(c.y_a + $urandom_range(10) - 1);
         end else begin
            c.x_b = 8'($urandom_range(WIDTH - 1));
            c.y_b = 8'($urandom_range(HEIGHT - 1));
         end
      end
      if (c.opcode == OP_RECT && (c.x_b - c.x_a) * (c.y_b - c.y_a) > 400 && c.x_b >= c.x_a
          && c.y_b >= c.y_a)
         c.x_b = 8'(c.x_a + 3);
      return c;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (byte_queue.size() == 0) report_mismatch("result with nothing expected");
         else if (rsp_read_byte !== byte_queue[0]) begin
            report_mismatch($sformatf("read_byte got %02h expected %02h",
                                      rsp_read_byte, byte_queue[0]));
            void'(byte_queue.pop_front());
         end else void'(byte_queue.pop_front());
      end
   end

   always @(posedge clock) begin
      if (hold_off_cycles != 0) begin
         rsp_stall <= 1'b1;
         hold_off_cycles <= hold_off_cycles - 1;
      end else rsp_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
   end

   table_row_type directed [$];
   table_row_type row;
   command_type cmd;
   int unsigned wait_cycles;

   initial begin
      foreach (pixel_store[i]) pixel_store[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reads after reset are zero; extremes and special cases follow
      directed.push_back('{make_command(OP_READ, 0, 0, 0, 0, 0, 0, 0), 1'b1, 8'h00});
      directed.push_back('{make_command(OP_READ, 255, 255, 255, 255, 1, 127, 7), 1'b1, 8'h00});
      directed.push_back('{make_command(OP_POINT, 0, 0, 0, 0, 1, 0, 0), 1'b1, 8'h00});
      directed.push_back('{make_command(OP_READ, 0, 0, 0, 0, 0, 0, 7), 1'b1, 8'h80});
      directed.push_back('{make_command(OP_POINT, 127, 63, 0, 0, 1, 0, 0), 1'b1, 8'h00});
      directed.push_back('{make_command(OP_READ, 0, 0, 0, 0, 0, 127, 0), 1'b1, 8'h01});
      directed.push_back('{make_command(OP_POINT, 128, 64, 0, 0, 1, 0, 0), 1'b0, 8'h00});
      directed.push_back('{make_command(OP_POINT, 127, 63, 0, 0, 0, 0, 0), 1'b0, 8'h00});
      directed.push_back('{make_command(OP_RECT, 10, 0, 12, 7, 1, 0, 0), 1'b0, 8'h00});
      directed.push_back('{make_command(OP_READ, 0, 0, 0, 0, 0, 11, 7), 1'b1, 8'hFF});
      directed.push_back('{make_command(OP_RECT, 12, 7, 10, 0, 1, 0, 0), 1'b0, 8'h00});
      directed.push_back('{make_command(OP_RECT, 120, 60, 255, 255, 1, 0, 0), 1'b0, 8'h00});
      directed.push_back('{make_command(OP_RECT, 11, 2, 11, 3, 0, 0, 0), 1'b0, 8'h00});
      directed.push_back('{make_command(OP_LINE, 0, 0, 30, 9, 0, 0, 0), 1'b0, 8'h00});
      directed.push_back('{make_command(OP_LINE, 40, 50, 35, 10, 0, 0, 0), 1'b0, 8'h00});
      directed.push_back('{make_command(OP_LINE, 0, 5, 5, 10, 0, 0, 0), 1'b0, 8'h00});
      directed.push_back('{make_command(OP_LINE, 127, 20, 127, 20, 0, 0, 0), 1'b0, 8'h00});
      directed.push_back('{make_command(OP_LINE, 255, 0, 250, 5, 0, 0, 0), 1'b0, 8'h00});
      directed.push_back('{make_command(OP_LINE, 200, 255, 200, 250, 0, 0, 0), 1'b0, 8'h00});
      directed.push_back('{make_command(OP_READ, 0, 0, 0, 0, 0, 0, 6), 1'b0, 8'h00});
      directed.push_back('{make_command(OP_READ, 0, 0, 0, 0, 0, 126, 0), 1'b0, 8'h00});
      directed.push_back('{make_command(3'd5, 1, 1, 1, 1, 1, 11, 7), 1'b1, 8'h00});
      directed.push_back('{make_command(3'd7, 1, 1, 1, 1, 1, 11, 7), 1'b1, 8'h00});
      directed.push_back('{make_command(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0), 1'b1, 8'h00});
      directed.push_back('{make_command(OP_READ, 0, 0, 0, 0, 0, 11, 7), 1'b1, 8'h00});

      foreach (directed[i]) begin
         row = directed[i];
         send_command(row.cmd);
         if (row.has_byte && byte_queue[$] !== row.byte_val)
            report_mismatch($sformatf("directed row %0d predicted %02h, table %02h",
                                      i, byte_queue[$], row.byte_val));
      end

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = phase == 0 ? 23 : (phase == 1 ? 81 : 0);
         recv_idle_pct = phase == 0 ? 81 : (phase == 1 ? 23 : 0);
         for (int n = 0; n < NUM_RANDOM / 3; n++) begin
            if (phase == 2 && n == 20) hold_off_cycles = 3000;
            cmd = random_command();
            send_command(cmd);
         end
      end
      req_valid <= 1'b0;

      wait_cycles = 0;
      while (byte_queue.size() != 0 && wait_cycles < 200_000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (1100) @(posedge clock);
      if (error_count == 0 && byte_queue.size() == 0) begin
         $display("mono_framebuffer_draw_engine: match");
      end else begin
         $display("mono_framebuffer_draw_engine: mismatch");
      end
      $finish;
   end

endmodule
